/* hw/rtl/arfc_pkg.sv */
// ---------------------------------------------------------------------------
// arfc_pkg
// shared constants, status codes and the closed-frame record
// ---------------------------------------------------------------------------
`default_nettype none

package arfc_pkg;

  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int READING_W = 19;
  localparam int NUM_KEPT  = 4;

  localparam logic [BYTE_W-1:0]  ASCII_ZERO = 8'd48;
  localparam logic [COUNT_W-1:0] FRAME_LEN  = 4'd8;
  localparam logic [COUNT_W-1:0] SUM_LEN    = 4'd7;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd9;

  // byte positions inside a frame
  localparam logic [COUNT_W-1:0] POS_THOUSANDS = 4'd2;
  localparam logic [COUNT_W-1:0] POS_HUNDREDS  = 4'd3;
  localparam logic [COUNT_W-1:0] POS_TENS      = 4'd4;
  localparam logic [COUNT_W-1:0] POS_UNITS     = 4'd6;
  localparam logic [COUNT_W-1:0] POS_CHECK     = 4'd7;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SUM_ERR = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0]                count;
    logic [BYTE_W-1:0]                 sum;
    logic [NUM_KEPT-1:0][BYTE_W-1:0]   digits;
    logic [BYTE_W-1:0]                 check;
  } frame_t;

endpackage

`default_nettype wire

/* hw/rtl/arfc_eval.sv */
// ---------------------------------------------------------------------------
// arfc_eval
// frame check and ascii digit to tenths conversion for one closed frame
// ---------------------------------------------------------------------------
`default_nettype none

module arfc_eval
  import arfc_pkg::*;
(
  input  wire frame_t                      frame,
  output logic [STATUS_W-1:0]              status,
  output logic signed [READING_W-1:0]      reading
);

  localparam int DIG_W  = BYTE_W + 1;
  localparam int PROD_W = READING_W + 1;

  logic signed [DIG_W-1:0]  dig [NUM_KEPT];
  logic signed [PROD_W-1:0] term [NUM_KEPT];
  logic signed [PROD_W-1:0] total;

  always_comb begin
    for (int i = 0; i < NUM_KEPT; i++) begin
      dig[i] = $signed({1'b0, frame.digits[i]}) - $signed({1'b0, ASCII_ZERO});
    end
    term[0] = PROD_W'(dig[0]) * PROD_W'(1000);
    term[1] = PROD_W'(dig[1]) * PROD_W'(100);
    term[2] = PROD_W'(dig[2]) * PROD_W'(10);
    term[3] = PROD_W'(dig[3]);
    total   = term[0] + term[1] + term[2] + term[3];
  end

  always_comb begin
    if (frame.count != FRAME_LEN) begin
      status  = STATUS_LEN_ERR;
      reading = '0;
    end else if (frame.check != frame.sum) begin
      status  = STATUS_SUM_ERR;
      reading = '0;
    end else begin
      status  = STATUS_OK;
      reading = total[READING_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ascii_reading_frame_checker_unit.sv */
// a closing item is registered in the closed frame stage, then its status and reading in the result register
// throughput: one item per cycle while s_axis_tready is high, taken by the byte accumulator
// a result waiting on m_axis_tready stalls input only once the frame stage is full
// reset: synchronous, active high; clears the byte count, running sum and valid flags
// ---------------------------------------------------------------------------
// ascii_reading_frame_checker_unit
// counts the bytes of one sensor burst, sums the first seven, keeps the digit
// and check bytes and reports status and reading in tenths when the burst closes
// ---------------------------------------------------------------------------
`default_nettype none

module ascii_reading_frame_checker_unit
  import arfc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // rx_byte
  input  wire         s_axis_tuser,   // has_byte
  input  wire         s_axis_tlast,   // burst_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // reading_tenths[18:0], zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  logic [COUNT_W-1:0]              count, count_next;
  logic [BYTE_W-1:0]               sum, sum_next;
  logic [NUM_KEPT-1:0][BYTE_W-1:0] digits, digits_next;
  logic [BYTE_W-1:0]               check, check_next;

  frame_t                   frame;
  logic                     frame_valid;
  logic                     advance;
  logic                     in_fire;
  logic [STATUS_W-1:0]      eval_status;
  logic signed [READING_W-1:0] eval_reading;
  logic [STATUS_W-1:0]      out_status;
  logic signed [READING_W-1:0] out_reading;

  assign advance       = frame_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !frame_valid || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    count_next  = count;
    sum_next    = sum;
    digits_next = digits;
    check_next  = check;
    if (s_axis_tuser) begin
      if (count < SUM_LEN) begin
        sum_next = sum + s_axis_tdata;
      end
      unique case (count)
        POS_THOUSANDS: digits_next[0] = s_axis_tdata;
        POS_HUNDREDS:  digits_next[1] = s_axis_tdata;
        POS_TENS:      digits_next[2] = s_axis_tdata;
        POS_UNITS:     digits_next[3] = s_axis_tdata;
        POS_CHECK:     check_next     = s_axis_tdata;
        default:       ;
      endcase
      if (count < COUNT_MAX) begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        count <= '0;
        sum   <= '0;
      end else begin
        count <= count_next;
        sum   <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      digits <= digits_next;
      check  <= check_next;
    end
  end

  // closed frame stage
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (in_fire && s_axis_tlast) begin
      frame_valid <= 1'b1;
    end else if (advance) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tlast) begin
      frame.count  <= count_next;
      frame.sum    <= sum_next;
      frame.digits <= digits_next;
      frame.check  <= check_next;
    end
  end

  arfc_eval u_eval (
    .frame   (frame),
    .status  (eval_status),
    .reading (eval_reading)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status  <= eval_status;
      out_reading <= eval_reading;
    end
  end

  assign m_axis_tdata = {5'b0, out_reading};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

/* hw/rtl/arfc_checker.sv */
// ---------------------------------------------------------------------------
// arfc_checker
// port-level checks on the result stream, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module arfc_checker
  import arfc_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        s_axis_tlast,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  // stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // status code is always a defined one
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_LEN_ERR ||
       m_axis_tuser == STATUS_SUM_ERR))
    else $error("undefined status");

  // an error result carries a zero reading
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == 24'd0)
    else $error("error result with nonzero reading");

  // a result after an idle output needs a closing item accepted while output was free
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid ##1 !m_axis_tvalid ##1 m_axis_tvalid |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a closing item");

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind ascii_reading_frame_checker_unit arfc_checker u_arfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
